[sv/pli_pkg.sv]
// shared constants, codes and controller/datapath handshake types for the interpolator
package pli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int FRAC_BITS  = 16;

	localparam int DATA_W = 32;
	localparam int PIDX_W = 6;
	localparam int CNT_W  = 7;
	localparam int ST_W   = 3;

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int N_W    = $clog2(MAX_POINTS + 1);

	// quotient bits kept by the divider; anything at or above 2^DIV_K saturates anyway
	localparam int DIV_K  = 34;
	localparam int DIVC_W = $clog2(DIV_K);
	localparam int SUM_W  = DIV_K + 3;

	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd2;

	typedef enum logic [0:0] {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} pli_req_kind_t;

	typedef enum logic [ST_W-1:0] {
		ST_INTERIOR = 3'd0,
		ST_LEFT     = 3'd1,
		ST_RIGHT    = 3'd2,
		ST_ZERO_DX  = 3'd3,
		ST_SAT      = 3'd4
	} pli_status_t;

	typedef struct packed {
		logic start;
		logic load_wr;
		logic scan;
		logic pick;
		logic rd_a;
		logic rd_b;
		logic cap_b;
		logic mag;
		logic mul;
		logic div_init;
		logic div_step;
		logic load_out;
	} pli_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic dx_zero;
		logic div_last;
		logic out_free;
	} pli_sts_t;

endpackage

[sv/pli_if.sv]
// request and result channel interfaces
interface pli_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic        [pli_pkg::PIDX_W-1:0]   point_index;
	logic signed [pli_pkg::DATA_W-1:0]   x_value;
	logic signed [pli_pkg::DATA_W-1:0]   y_value;
	logic signed [pli_pkg::DATA_W-1:0]   query_x;

	modport source (
		output valid, req_type, point_index, x_value, y_value, query_x,
		input  ready
	);
	modport sink (
		input  valid, req_type, point_index, x_value, y_value, query_x,
		output ready
	);
endinterface

interface pli_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [pli_pkg::DATA_W-1:0]   y_out;
	logic signed [pli_pkg::DATA_W-1:0]   slope_out;
	logic        [pli_pkg::ST_W-1:0]     status;

	modport source (
		output valid, y_out, slope_out, status,
		input  ready
	);
	modport sink (
		input  valid, y_out, slope_out, status,
		output ready
	);
endinterface

[sv/pli_ram.sv]
// generic single-write, single-read ram with registered read data
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/pli_ctrl.sv]
// sequencing state machine for load and query words
module pli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_type,
	output logic              req_ready,
	input  pli_pkg::pli_sts_t sts,
	output pli_pkg::pli_cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_SCAN     = 12'b0000_0000_0010,
		S_DRAIN    = 12'b0000_0000_0100,
		S_PICK     = 12'b0000_0000_1000,
		S_RD_A     = 12'b0000_0001_0000,
		S_RD_B     = 12'b0000_0010_0000,
		S_CAP_B    = 12'b0000_0100_0000,
		S_MAG      = 12'b0000_1000_0000,
		S_MUL      = 12'b0001_0000_0000,
		S_DIV_INIT = 12'b0010_0000_0000,
		S_DIV      = 12'b0100_0000_0000,
		S_FIN      = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_type == pli_pkg::REQ_QUERY) begin
						cmd.start = 1'b1;
						state_d   = S_SCAN;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_RD_A;
			end
			S_RD_A: begin
				cmd.rd_a = 1'b1;
				state_d  = S_RD_B;
			end
			S_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = S_CAP_B;
			end
			S_CAP_B: begin
				cmd.cap_b = 1'b1;
				state_d   = S_MAG;
			end
			S_MAG: begin
				cmd.mag = 1'b1;
				state_d = sts.dx_zero ? S_FIN : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[sv/pli_dp.sv]
// datapath: breakpoint scan, segment fetch, multiply, dual restoring divide, saturation
module pli_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic        [pli_pkg::CNT_W-1:0]    cfg_data,
	input  logic        [pli_pkg::PIDX_W-1:0]   point_index,
	input  logic signed [pli_pkg::DATA_W-1:0]   x_value,
	input  logic signed [pli_pkg::DATA_W-1:0]   y_value,
	input  logic signed [pli_pkg::DATA_W-1:0]   query_x,
	input  pli_pkg::pli_cmd_t                   cmd,
	output pli_pkg::pli_sts_t                   sts,
	output logic                                ram_we,
	output logic        [pli_pkg::ADDR_W-1:0]   ram_waddr,
	output logic        [pli_pkg::DATA_W-1:0]   x_wdata,
	output logic        [pli_pkg::DATA_W-1:0]   y_wdata,
	output logic        [pli_pkg::ADDR_W-1:0]   ram_raddr,
	input  logic        [pli_pkg::DATA_W-1:0]   x_rdata,
	input  logic        [pli_pkg::DATA_W-1:0]   y_rdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pli_pkg::DATA_W-1:0]   y_out,
	output logic signed [pli_pkg::DATA_W-1:0]   slope_out,
	output logic        [pli_pkg::ST_W-1:0]     status
);

	localparam int NW = pli_pkg::N_W;
	localparam int AW = pli_pkg::ADDR_W;
	localparam int K  = pli_pkg::DIV_K;
	localparam int CW = pli_pkg::DIVC_W;
	localparam int SW = pli_pkg::SUM_W;
	localparam int MP = pli_pkg::MAX_POINTS;

	localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd2147483648);

	logic [pli_pkg::CNT_W-1:0] pcount_q;

	logic signed [31:0] q_q, x0_q, prev_q, xlast_q, xa_q, ya_q, yanc_q;
	logic [NW-1:0] n_q, ptr_q, n_start, pick_a;
	logic [NW-1:0] tag_idx_s1;
	logic          tag_v_s1;
	logic [AW-1:0] sel_q;
	pli_pkg::pli_status_t seg_st_q, pick_st;

	logic signed [32:0] dx_q, dy_q, off_q;
	logic [31:0] mdx_q, mdy_q, moff_q;
	logic        neg_y_q, neg_s_q;
	logic [63:0] prod_q, sdv_q;

	logic [31:0]  ry_q, rs_q;
	logic [K-1:0] ly_q, ls_q;
	logic         big_y_q, big_s_q;
	logic [CW-1:0] cnt_q;

	logic signed [31:0] rd_x, rd_y, xb_anc, yb_anc;
	logic [32:0] ry2, rs2;
	logic        ge_y, ge_s;

	logic [K:0]          my, ms;
	logic signed [SW-1:0] my_s, ms_s, ysum, ssum;
	logic                y_sat, s_sat;
	logic signed [31:0]  y_fin, s_fin;
	pli_pkg::pli_status_t st_fin;

	assign rd_x = signed'(x_rdata);
	assign rd_y = signed'(y_rdata);

	// loads go straight into the stores
	assign ram_we    = cmd.load_wr && (32'(point_index) < 32'(MP));
	assign ram_waddr = AW'(point_index);
	assign x_wdata   = x_value;
	assign y_wdata   = y_value;
	assign ram_raddr = ptr_q[AW-1:0];

	// clamp the configured count into two up to the store depth
	always_comb begin
		if (pcount_q < pli_pkg::CNT_W'(2)) begin
			n_start = NW'(2);
		end else if (32'(pcount_q) > 32'(MP)) begin
			n_start = NW'(MP);
		end else begin
			n_start = NW'(pcount_q);
		end
	end

	always_comb begin
		if (q_q <= x0_q) begin
			pick_a  = '0;
			pick_st = pli_pkg::ST_LEFT;
		end else if (q_q >= xlast_q) begin
			pick_a  = n_q - NW'(2);
			pick_st = pli_pkg::ST_RIGHT;
		end else begin
			pick_a  = NW'(sel_q);
			pick_st = pli_pkg::ST_INTERIOR;
		end
	end

	// right extrapolation anchors on the last point
	assign xb_anc = (seg_st_q == pli_pkg::ST_RIGHT) ? rd_x : xa_q;
	assign yb_anc = (seg_st_q == pli_pkg::ST_RIGHT) ? rd_y : ya_q;

	// one restoring step for each quotient
	assign ry2  = {ry_q, ly_q[K-1]};
	assign rs2  = {rs_q, ls_q[K-1]};
	assign ge_y = ry2 >= {1'b0, mdx_q};
	assign ge_s = rs2 >= {1'b0, mdx_q};

	// sign, saturate and pick the status
	always_comb begin
		my    = {big_y_q, big_y_q ? {K{1'b0}} : ly_q};
		ms    = {big_s_q, big_s_q ? {K{1'b0}} : ls_q};
		my_s  = signed'(SW'(my));
		ms_s  = signed'(SW'(ms));
		ysum  = SW'(yanc_q) + (neg_y_q ? -my_s : my_s);
		ssum  = neg_s_q ? -ms_s : ms_s;
		y_sat = (ysum > SAT_HI) || (ysum < SAT_LO);
		s_sat = (ssum > SAT_HI) || (ssum < SAT_LO);
		if (y_sat) begin
			y_fin = ysum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			y_fin = ysum[31:0];
		end
		if (s_sat) begin
			s_fin = ssum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			s_fin = ssum[31:0];
		end
		if (dx_q == '0) begin
			y_fin  = yanc_q;
			s_fin  = '0;
			st_fin = pli_pkg::ST_ZERO_DX;
		end else if (y_sat || s_sat) begin
			st_fin = pli_pkg::ST_SAT;
		end else begin
			st_fin = seg_st_q;
		end
	end

	assign sts.scan_last = (ptr_q == n_q - NW'(1));
	assign sts.dx_zero   = (dx_q == '0);
	assign sts.div_last  = (cnt_q == CW'(K - 1));
	assign sts.out_free  = !out_valid || out_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= pli_pkg::COUNT_RESET;
			tag_v_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				pcount_q <= cfg_data;
			end
			tag_v_s1 <= cmd.scan;
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q   <= query_x;
			n_q   <= n_start;
			ptr_q <= '0;
		end
		if (cmd.scan) begin
			tag_idx_s1 <= ptr_q;
			ptr_q      <= ptr_q + NW'(1);
		end
		// compare on the registered read data, tagged with the index it was read from
		if (tag_v_s1) begin
			if (tag_idx_s1 == '0) begin
				x0_q  <= rd_x;
				sel_q <= '0;
			end else begin
				if ((prev_q <= q_q) && (q_q < rd_x)) begin
					sel_q <= AW'(tag_idx_s1 - NW'(1));
				end
				xlast_q <= rd_x;
			end
			prev_q <= rd_x;
		end
		if (cmd.pick) begin
			ptr_q    <= pick_a;
			seg_st_q <= pick_st;
		end
		if (cmd.rd_a) begin
			ptr_q <= ptr_q + NW'(1);
		end
		if (cmd.rd_b) begin
			xa_q <= rd_x;
			ya_q <= rd_y;
		end
		if (cmd.cap_b) begin
			dx_q   <= 33'(rd_x) - 33'(xa_q);
			dy_q   <= 33'(rd_y) - 33'(ya_q);
			off_q  <= 33'(q_q) - 33'(xb_anc);
			yanc_q <= yb_anc;
		end
		if (cmd.mag) begin
			mdx_q   <= dx_q[32] ? 32'(-dx_q) : 32'(dx_q);
			mdy_q   <= dy_q[32] ? 32'(-dy_q) : 32'(dy_q);
			moff_q  <= off_q[32] ? 32'(-off_q) : 32'(off_q);
			neg_y_q <= dy_q[32] ^ off_q[32] ^ dx_q[32];
			neg_s_q <= dy_q[32] ^ dx_q[32];
		end
		if (cmd.mul) begin
			prod_q <= 64'(mdy_q) * 64'(moff_q);
			sdv_q  <= 64'(mdy_q) << pli_pkg::FRAC_BITS;
		end
		// high part at or above the divisor means the quotient overflows
		if (cmd.div_init) begin
			ry_q    <= 32'(prod_q >> K);
			rs_q    <= 32'(sdv_q >> K);
			big_y_q <= (prod_q >> K) >= 64'(mdx_q);
			big_s_q <= (sdv_q >> K) >= 64'(mdx_q);
			ly_q    <= prod_q[K-1:0];
			ls_q    <= sdv_q[K-1:0];
			cnt_q   <= '0;
		end
		if (cmd.div_step) begin
			ry_q  <= ge_y ? 32'(ry2 - {1'b0, mdx_q}) : ry2[31:0];
			rs_q  <= ge_s ? 32'(rs2 - {1'b0, mdx_q}) : rs2[31:0];
			ly_q  <= {ly_q[K-2:0], ge_y};
			ls_q  <= {ls_q[K-2:0], ge_s};
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.load_out) begin
			y_out     <= y_fin;
			slope_out <= s_fin;
			status    <= st_fin;
		end
	end

endmodule

[sv/piecewise_linear_interpolator_top.sv]
// top level of the piecewise linear interpolator
// load word: taken while idle, written to both stores, no result word
// query word: a one-x-per-cycle scan of the stored points, segment fetch, multiply and a 34-step
//   restoring divider to the result register; a zero-width segment skips multiply and divide
// one word at a time: a query blocks input until its result is loaded, longer if the result waits
// reset clears the controller, the result valid and sets point_count to 2; stores hold no reset
module piecewise_linear_interpolator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pli_pkg::CNT_W-1:0]    cfg_data,
	pli_req_if.sink                      req,
	pli_rsp_if.source                    rsp
);

	pli_pkg::pli_cmd_t cmd;
	pli_pkg::pli_sts_t sts;

	// store write enable and addresses shared by the x and y memories; data ports per memory
	logic                        ram_we;
	logic [pli_pkg::ADDR_W-1:0]  ram_waddr;
	logic [pli_pkg::ADDR_W-1:0]  ram_raddr;
	logic [pli_pkg::DATA_W-1:0]  x_wdata, y_wdata;
	logic [pli_pkg::DATA_W-1:0]  x_rdata, y_rdata;

	// sequencer: only ready in idle, steps the datapath through a query
	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// scan, fetch, multiply, divide and saturate; also owns the result register
	pli_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.point_index (req.point_index),
		.x_value     (req.x_value),
		.y_value     (req.y_value),
		.query_x     (req.query_x),
		.cmd         (cmd),
		.sts         (sts),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.x_wdata     (x_wdata),
		.y_wdata     (y_wdata),
		.ram_raddr   (ram_raddr),
		.x_rdata     (x_rdata),
		.y_rdata     (y_rdata),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.y_out       (rsp.y_out),
		.slope_out   (rsp.slope_out),
		.status      (rsp.status)
	);

	// breakpoint x coordinates
	pli_ram #(
		.WIDTH (pli_pkg::DATA_W),
		.DEPTH (pli_pkg::MAX_POINTS)
	) u_x_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (x_wdata),
		.raddr (ram_raddr),
		.rdata (x_rdata)
	);

	// breakpoint y values
	pli_ram #(
		.WIDTH (pli_pkg::DATA_W),
		.DEPTH (pli_pkg::MAX_POINTS)
	) u_y_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (y_wdata),
		.raddr (ram_raddr),
		.rdata (y_rdata)
	);

	// a query word keeps the block busy on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == pli_pkg::REQ_QUERY) |=> !req.ready)
		else $error("ready still high after a query word");

	// a load word never brings up a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == pli_pkg::REQ_LOAD && !rsp.valid)
		|=> !rsp.valid)
		else $error("result word after a load");

	// a fresh result only comes out of a running query
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result word appeared while idle");

	// zero-width segment reports a flat slope
	a_zero_dx_slope: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == pli_pkg::ST_ZERO_DX) |-> (rsp.slope_out == '0))
		else $error("zero-width segment with nonzero slope");

endmodule
